// ===== rtl/sorted_priority_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared concurrent assertion forms for the queue RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, codes and types shared by the queue modules and channels.
// ----------------------------------------------------------------------------
package spq_pkg;

	// Storage depth and derived widths
	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CAP_W  = 5;
	localparam int FILL_W = 5;
	localparam int WIDE_W = (CNT_W > FILL_W) ? CNT_W : FILL_W;
	localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef logic signed [31:0] value_t;
	typedef logic signed [15:0] prio_t;

	typedef enum logic [1:0] {
		ST_PUSHED   = 2'd0,
		ST_POPPED   = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		value_t value;
		prio_t  prio;
	} entry_t;

	typedef struct packed {
		logic   op;
		value_t value;
		prio_t  prio;
	} req_t;

	typedef struct packed {
		status_t           status;
		value_t            value;
		prio_t             prio;
		logic [FILL_W-1:0] fill;
	} rsp_t;

	// Report an entry count in the fill field width (modulo wrap)
	function automatic logic [FILL_W-1:0] fill_of(logic [CNT_W-1:0] c);
		logic [WIDE_W-1:0] w;
		w = WIDE_W'(c);
		return w[FILL_W-1:0];
	endfunction

endpackage

// ===== rtl/spq_in_if.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue request channel
// Valid/ready channel carrying one push or pop request.
// ----------------------------------------------------------------------------
interface spq_in_if;
	import spq_pkg::*;

	logic   valid;
	logic   ready;
	logic   op;
	value_t value;
	prio_t  priority_req;

	modport source (output valid, output op, output value, output priority_req, input ready);
	modport sink   (input valid, input op, input value, input priority_req, output ready);
endinterface

// ===== rtl/spq_out_if.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface spq_out_if;
	import spq_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        status;
	value_t            out_value;
	prio_t             out_priority;
	logic [FILL_W-1:0] fill;

	modport source (output valid, output status, output out_value, output out_priority,
		output fill, input ready);
	modport sink   (input valid, input status, input out_value, input out_priority,
		input fill, output ready);
endinterface

// ===== rtl/spq_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue configuration channel
// Valid/ready write channel for the capacity register.
// ----------------------------------------------------------------------------
interface spq_cfg_if;
	import spq_pkg::*;

	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] capacity;

	modport source (output valid, output capacity, input ready);
	modport sink   (input valid, input capacity, output ready);
endinterface

// ===== rtl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue
// Up to DEPTH value/priority entries kept in priority order, one result per
// request.
// ----------------------------------------------------------------------------
// A push compares the new entry with the stored entries from the tail,
// moves each stored entry of lower priority up one place, then writes the
// new entry. A pop captures the head, then moves each remaining entry down
// one place. Overflow and empty pops go straight to the result. The single
// entry store moves one entry per cycle through its one write port and one
// registered read port. The request channel is ready again in the cycle after
// a result is loaded. The request channel is not ready while a request is
// being worked on. A finished result sits in an output register, so the next
// request is taken while the result waits. Capacity is written through the
// configuration channel, which is always ready. The store needs no clearing
// after reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
	input  logic   clk,
	input  logic   arst_n,
	spq_in_if.sink    req,
	spq_out_if.source rsp,
	spq_cfg_if.sink   cfg
);
	import spq_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	logic             out_valid_q;
	rsp_t             out_q;
	logic             eng_busy;
	logic             eng_done;
	logic             eng_start;
	logic             rsp_free;
	req_t             eng_req;
	rsp_t             eng_rsp;

	assign cfg.ready = 1'b1;
	assign req.ready = !eng_busy;
	assign eng_start = req.valid && !eng_busy;
	assign rsp_free  = !out_valid_q || rsp.ready;
	assign eng_req   = '{op: req.op, value: req.value, prio: req.priority_req};

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			capacity_q <= cfg.capacity;
		end
	end

	spq_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (eng_start),
		.req       (eng_req),
		.cap       (capacity_q),
		.rsp_ready (rsp_free),
		.busy      (eng_busy),
		.done      (eng_done),
		.rsp       (eng_rsp)
	);

	// Output register: load on completion, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (eng_done) begin
				out_valid_q <= 1'b1;
				out_q       <= eng_rsp;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_q.status;
	assign rsp.out_value    = out_q.value;
	assign rsp.out_priority = out_q.prio;
	assign rsp.fill         = out_q.fill;

endmodule

// ===== rtl/spq_engine.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue engine
// Entry store with one write and one registered read port, walked by a
// small sequencer that shifts one entry per cycle on insert and on removal.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_macros.svh"

module spq_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  spq_pkg::req_t             req,
	input  logic [spq_pkg::CAP_W-1:0] cap,
	input  logic                      rsp_ready,
	output logic                      busy,
	output logic                      done,
	output spq_pkg::rsp_t             rsp
);
	import spq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH_CMP,
		S_PUSH_INS,
		S_POP_HEAD,
		S_POP_SHIFT,
		S_RESP
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] pos_q;
	entry_t           new_q;
	entry_t           rd_q;
	rsp_t             res_q;

	entry_t           mem [DEPTH];

	logic [CNT_W-1:0] cnt_m1;
	logic [CNT_W-1:0] cnt_p1;
	logic [CNT_W-1:0] pos_m1;
	logic [CNT_W-1:0] pos_m2;
	logic [CNT_W-1:0] pos_p1;
	logic             full;
	logic             shift_en;
	logic [IDX_W-1:0] raddr;
	logic [IDX_W-1:0] waddr;
	logic             we;
	entry_t           wdata;

	assign cnt_m1   = count_q - CNT_W'(1);
	assign cnt_p1   = count_q + CNT_W'(1);
	assign pos_m1   = pos_q - CNT_W'(1);
	assign pos_m2   = pos_q - CNT_W'(2);
	assign pos_p1   = pos_q + CNT_W'(1);
	assign full     = (CMP_W'(count_q) >= CMP_W'(cap)) || (count_q == CNT_W'(DEPTH));
	assign shift_en = $signed(rd_q.prio) < $signed(new_q.prio);

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP) && rsp_ready;
	assign rsp  = res_q;

	// Select store addresses for the current step
	always_comb begin
		raddr = '0;
		waddr = '0;
		we    = 1'b0;
		wdata = new_q;
		unique case (state_q)
			S_IDLE: begin
				if (start && req.op == OP_PUSH) begin
					raddr = cnt_m1[IDX_W-1:0];
				end
			end
			S_PUSH_CMP: begin
				we    = 1'b1;
				waddr = pos_q[IDX_W-1:0];
				if (shift_en) begin
					wdata = rd_q;
					raddr = pos_m2[IDX_W-1:0];
				end
			end
			S_PUSH_INS: begin
				we    = 1'b1;
				waddr = pos_q[IDX_W-1:0];
			end
			S_POP_HEAD: begin
				raddr = pos_q[IDX_W-1:0];
			end
			S_POP_SHIFT: begin
				we    = 1'b1;
				waddr = pos_m1[IDX_W-1:0];
				wdata = rd_q;
				raddr = pos_p1[IDX_W-1:0];
			end
			S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// Entry store: one write, one registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pos_q   <= '0;
			new_q   <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						new_q       <= '{value: req.value, prio: req.prio};
						res_q.value <= '0;
						res_q.prio  <= '0;
						res_q.fill  <= fill_of(count_q);
						if (req.op == OP_PUSH) begin
							if (full) begin
								res_q.status <= ST_OVERFLOW;
								state_q      <= S_RESP;
							end else begin
								pos_q   <= count_q;
								state_q <= (count_q == '0) ? S_PUSH_INS : S_PUSH_CMP;
							end
						end else begin
							if (count_q == '0) begin
								res_q.status <= ST_EMPTY;
								state_q      <= S_RESP;
							end else begin
								pos_q   <= CNT_W'(1);
								state_q <= S_POP_HEAD;
							end
						end
					end
				end
				S_PUSH_CMP: begin
					if (shift_en) begin
						// Move the lower-priority entry up one place
						pos_q <= pos_m1;
						if (pos_q == CNT_W'(1)) begin
							state_q <= S_PUSH_INS;
						end
					end else begin
						count_q      <= cnt_p1;
						res_q.status <= ST_PUSHED;
						res_q.fill   <= fill_of(cnt_p1);
						state_q      <= S_RESP;
					end
				end
				S_PUSH_INS: begin
					count_q      <= cnt_p1;
					res_q.status <= ST_PUSHED;
					res_q.fill   <= fill_of(cnt_p1);
					state_q      <= S_RESP;
				end
				S_POP_HEAD: begin
					// Capture the head, then close the gap
					res_q.value  <= rd_q.value;
					res_q.prio   <= rd_q.prio;
					res_q.status <= ST_POPPED;
					if (pos_q < count_q) begin
						state_q <= S_POP_SHIFT;
					end else begin
						count_q    <= cnt_m1;
						res_q.fill <= fill_of(cnt_m1);
						state_q    <= S_RESP;
					end
				end
				S_POP_SHIFT: begin
					if (pos_p1 < count_q) begin
						pos_q <= pos_p1;
					end else begin
						count_q    <= cnt_m1;
						res_q.fill <= fill_of(cnt_m1);
						state_q    <= S_RESP;
					end
				end
				S_RESP: begin
					if (rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "entry count above depth")
	`SPQ_ASSERT_NEXT(a_push_grows, state_q == S_PUSH_INS, count_q == $past(cnt_p1), "insert did not grow count")
	`SPQ_ASSERT_NOW(a_shift_range, state_q == S_POP_SHIFT, pos_q < count_q && pos_q != '0, "removal shift out of range")
	`SPQ_ASSERT_NOW(a_cmp_range, state_q == S_PUSH_CMP, pos_q != '0 && pos_q <= count_q, "insert compare out of range")

endmodule
